// ----- hw/rtl/set_assoc_cache_tag_store_defines.svh -----
// Assertion macros for the tag store
`ifndef SET_ASSOC_CACHE_TAG_STORE_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_STORE_DEFINES_SVH
// Implication checked every cycle outside reset
`define SACTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define SACTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hw/rtl/sacts_pkg.sv -----
// ----------------------------------------------------------------------------
// sacts_pkg
// Shared constants and types of the cache tag store.
// ----------------------------------------------------------------------------
package sacts_pkg;
  localparam int MaxSetBits = 8;
  localparam int MaxWayBits = 3;
  localparam int TagWidth   = 48;
  localparam int NumWays    = 1 << MaxWayBits;
  localparam int NumSets    = 1 << MaxSetBits;
  localparam int NumLines   = NumSets * NumWays;

  typedef logic [MaxWayBits-1:0] way_t;
  typedef logic [MaxSetBits-1:0] set_t;
  typedef logic [TagWidth-1:0]   tag_t;

  // action codes
  localparam logic [1:0] ActLookup   = 2'd0;
  localparam logic [1:0] ActInstall  = 2'd1;
  localparam logic [1:0] ActPrefetch = 2'd2;

  // register indexes
  localparam logic [2:0] RegReplaceLfu = 3'd0;
  localparam logic [2:0] RegWbAlloc    = 3'd1;
  localparam logic [2:0] RegPrefLip    = 3'd2;
  localparam logic [2:0] RegDisabled   = 3'd3;
  localparam logic [2:0] RegOffset     = 3'd4;
  localparam logic [2:0] RegIndex      = 3'd5;
  localparam logic [2:0] RegWay        = 3'd6;

  // one way's state as stored in memory
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic        mru;
    tag_t        tag;
    logic [63:0] stamp;
    logic [31:0] cnt;
  } line_t;

  // victim choice handed from selector to top level
  typedef struct packed {
    way_t        way;
    logic        low_ok;
    logic [63:0] low_stamp;
  } victim_t;
endpackage

// ----- hw/rtl/sacts_victim.sv -----
// ----------------------------------------------------------------------------
// sacts_victim
// Picks the way to replace in one set: empty way first, else LRU or LFU.
// ----------------------------------------------------------------------------
module sacts_victim import sacts_pkg::*; (
  input  line_t           lines [NumWays],
  input  logic [NumWays-1:0] way_en,
  input  logic            lfu,
  output victim_t         pick
);
  // scan ways in order, mirroring the priority rules of the policy
  always_comb begin
    logic        empty;
    logic        have;
    logic        better;
    way_t        vic;
    logic [63:0] lo_stamp;
    logic [31:0] lo_cnt;
    empty = 1'b0;
    have = 1'b0;
    vic = '0;
    lo_stamp = '0;
    lo_cnt = '0;
    for (int w = 0; w < NumWays; w++) begin
      better = 1'b0;
      if (way_en[w]) begin
        if (!lines[w].valid) begin
          vic = way_t'(w);
          empty = 1'b1;
        end else begin
          if (lfu) begin
            if (!lines[w].mru) begin
              if (!have || lines[w].cnt < lo_cnt) begin
                have = 1'b1;
                lo_cnt = lines[w].cnt;
                better = 1'b1;
              end else if (lines[w].cnt == lo_cnt && !empty &&
                           lines[w].tag < lines[vic].tag) begin
                better = 1'b1;
              end
            end
          end else if (!have || lines[w].stamp < lo_stamp) begin
            have = 1'b1;
            lo_stamp = lines[w].stamp;
            better = 1'b1;
          end
          if (!empty && better) vic = way_t'(w);
        end
      end
    end
    pick.way = vic;
    pick.low_ok = have;
    pick.low_stamp = lo_stamp;
  end
endmodule

// ----- hw/rtl/set_assoc_cache_tag_store.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store
// Tag store of a set-associative cache with LRU or LFU-with-MRU replacement.
// ----------------------------------------------------------------------------
// The accepting edge reads the set from the line memory into a register, the
// S_READ state holds the read, and S_WRITE compares the ways, writes the set
// back and registers the result. A new item may be accepted while the
// previous result still waits; it then holds in its write-back cycle until
// that result is taken. After reset a clearing pass over all 256 sets (one
// set per cycle) runs before the first item is accepted; configuration
// writes are taken throughout.
module set_assoc_cache_tag_store import sacts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic        is_write,
  input  logic [47:0] line_tag,
  input  logic [7:0]  set_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic        evicted,
  output logic        writeback_needed,
  output logic [63:0] writeback_addr
);
  `include "set_assoc_cache_tag_store_defines.svh"

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;

  state_t      state;
  set_t        clr_set;
  logic        replace_lfu, write_back_allocate, prefetch_lip, cache_disabled;
  logic [3:0]  offset_bits, index_bits;
  logic [1:0]  way_bits;
  logic [63:0] stamp_counter;

  logic [1:0]  q_action;
  logic        q_write;
  tag_t        q_tag;
  set_t        q_set;

  line_t       mem [NumSets][NumWays];
  line_t       rd [NumWays];
  line_t       wr_line [NumWays];
  logic        mem_we;
  set_t        mem_addr;
  set_t        rd_addr;
  logic        advance;

  logic [3:0]  eff_ib;
  logic [1:0]  eff_wb;
  logic [NumWays-1:0] way_en;
  set_t        set_mask;

  // effective geometry
  always_comb begin
    eff_ib = (index_bits > 4'(MaxSetBits)) ? 4'(MaxSetBits) : index_bits;
    eff_wb = way_bits;
    for (int w = 0; w < NumWays; w++) way_en[w] = (w < (1 << eff_wb));
    set_mask = set_t'((9'd1 << eff_ib) - 9'd1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_lfu <= 1'b0;
      write_back_allocate <= 1'b1;
      prefetch_lip <= 1'b0;
      cache_disabled <= 1'b0;
      offset_bits <= 4'd6;
      index_bits <= 4'd8;
      way_bits <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        RegReplaceLfu: replace_lfu <= cfg_data[0];
        RegWbAlloc:    write_back_allocate <= cfg_data[0];
        RegPrefLip:    prefetch_lip <= cfg_data[0];
        RegDisabled:   cache_disabled <= cfg_data[0];
        RegOffset:     offset_bits <= cfg_data;
        RegIndex:      index_bits <= cfg_data;
        RegWay:        way_bits <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // compare ways and choose victim
  logic [NumWays-1:0] match;
  logic               found;
  way_t               hit_way;
  victim_t            pick;

  always_comb begin
    match = '0;
    found = 1'b0;
    hit_way = '0;
    for (int w = NumWays - 1; w >= 0; w--) begin
      match[w] = way_en[w] && rd[w].valid && rd[w].tag == q_tag;
      if (match[w]) begin
        found = 1'b1;
        hit_way = way_t'(w);
      end
    end
  end

  sacts_victim u_victim (
    .lines  (rd),
    .way_en (way_en),
    .lfu    (replace_lfu),
    .pick   (pick)
  );

  // build written-back set and result
  logic        r_hit, r_ev, r_wb, stamp_inc;
  logic [63:0] r_addr;
  line_t       vl;

  always_comb begin
    wr_line = rd;
    r_hit = 1'b0;
    r_ev = 1'b0;
    r_wb = 1'b0;
    r_addr = '0;
    stamp_inc = 1'b0;
    vl = rd[pick.way];
    if (q_action == ActLookup) begin
      if (!cache_disabled && found) begin
        r_hit = 1'b1;
        if (replace_lfu) begin
          if (wr_line[hit_way].cnt != '1) wr_line[hit_way].cnt = rd[hit_way].cnt + 32'd1;
          for (int w = 0; w < NumWays; w++) if (way_en[w]) wr_line[w].mru = 1'b0;
          wr_line[hit_way].mru = 1'b1;
        end else begin
          wr_line[hit_way].stamp = stamp_counter;
          stamp_inc = 1'b1;
        end
        if (q_write && write_back_allocate) wr_line[hit_way].dirty = 1'b1;
      end
    end else if (q_action == ActInstall || q_action == ActPrefetch) begin
      if (q_action == ActPrefetch && found) begin
        r_hit = 1'b1;
      end else begin
        if (vl.valid) begin
          r_ev = 1'b1;
          if (vl.dirty && write_back_allocate) begin
            r_wb = 1'b1;
            r_addr = (64'(vl.tag) << (5'(eff_ib) + 5'(offset_bits))) |
                     (64'(q_set) << offset_bits);
          end
        end
        wr_line[pick.way].valid = 1'b1;
        wr_line[pick.way].tag = q_tag;
        if (q_action == ActInstall) begin
          wr_line[pick.way].dirty = q_write && write_back_allocate;
          if (replace_lfu) begin
            wr_line[pick.way].cnt = 32'd1;
            for (int w = 0; w < NumWays; w++) if (way_en[w]) wr_line[w].mru = 1'b0;
            wr_line[pick.way].mru = 1'b1;
          end else begin
            wr_line[pick.way].stamp = stamp_counter;
            stamp_inc = 1'b1;
          end
        end else begin
          wr_line[pick.way].dirty = 1'b0;
          if (replace_lfu) begin
            if (prefetch_lip) begin
              wr_line[pick.way].mru = 1'b0;
            end else begin
              for (int w = 0; w < NumWays; w++) if (way_en[w]) wr_line[w].mru = 1'b0;
              wr_line[pick.way].mru = 1'b1;
            end
            wr_line[pick.way].cnt = '0;
          end else begin
            wr_line[pick.way].stamp = (prefetch_lip && pick.low_ok) ?
                                      pick.low_stamp - 64'd1 : stamp_counter;
            stamp_inc = 1'b1;
          end
        end
      end
    end
  end

  // write back only once the result register is free
  assign advance = !out_valid || out_ready;

  // line memory: one set per address, read registered
  always_comb begin
    mem_we = (state == S_CLEAR) || ((state == S_WRITE) && advance);
    mem_addr = (state == S_CLEAR) ? clr_set : q_set;
    rd_addr = (state == S_IDLE) ? set_t'(set_index & set_mask) : q_set;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int w = 0; w < NumWays; w++) begin
        if (state == S_CLEAR) begin
          mem[mem_addr][w] <= '0;
        end else begin
          mem[mem_addr][w] <= wr_line[w];
        end
      end
    end
    for (int w = 0; w < NumWays; w++) rd[w] <= mem[rd_addr][w];
  end

  assign in_ready = (state == S_IDLE);

  // sequencer, item capture and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_set <= '0;
      out_valid <= 1'b0;
      stamp_counter <= 64'd4096;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_set <= clr_set + set_t'(1);
          if (clr_set == set_t'(NumSets - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) state <= S_READ;
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (advance) begin
            hit <= r_hit;
            evicted <= r_ev;
            writeback_needed <= r_wb;
            writeback_addr <= r_addr;
            out_valid <= 1'b1;
            if (stamp_inc) stamp_counter <= stamp_counter + 64'd1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // hold the item while its set is read
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_action <= action;
      q_write <= is_write;
      q_tag <= line_tag;
      q_set <= set_index & set_mask;
    end
  end

  `SACTS_ASSERT_IMP(a_no_accept_busy, state != S_IDLE, !in_ready, "accept while busy")
  `SACTS_ASSERT_NEXT(a_write_gives_result, state == S_WRITE, out_valid, "result not shown")
  `SACTS_ASSERT_IMP(a_wb_implies_ev, out_valid && writeback_needed, evicted,
                    "writeback without eviction")
  `SACTS_ASSERT_NEXT(a_accept_reads, in_valid && in_ready, state == S_READ, "read skipped")
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cache tag store: random lookups, installs and
// prefetches under a range of policy and geometry settings, each result
// compared against a cycle-free predictor of the set contents.
// ----------------------------------------------------------------------------
module tb;
  import sacts_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 180;
  localparam int NumPhases  = 8;

  typedef struct {
    logic [1:0]  act;
    logic        wr;
    logic [47:0] tag;
    logic [7:0]  set;
  } item_t;

  typedef struct {
    logic        hit;
    logic        evicted;
    logic        wb;
    logic [63:0] addr;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic        is_write;
  logic [47:0] line_tag;
  logic [7:0]  set_index;
  logic        out_valid;
  logic        out_ready;
  logic        hit;
  logic        evicted;
  logic        writeback_needed;
  logic [63:0] writeback_addr;

  set_assoc_cache_tag_store u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .is_write(is_write), .line_tag(line_tag), .set_index(set_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .evicted(evicted), .writeback_needed(writeback_needed),
    .writeback_addr(writeback_addr)
  );

  // shadow copy of the tag store
  logic        sh_valid [NumLines];
  logic        sh_dirty [NumLines];
  logic        sh_mru   [NumLines];
  logic [47:0] sh_tag   [NumLines];
  logic [63:0] sh_stamp [NumLines];
  logic [31:0] sh_cnt   [NumLines];
  logic [63:0] sh_clock;
  logic        c_lfu, c_wb, c_lip, c_dis;
  logic [3:0]  c_off, c_idx;
  logic [1:0]  c_way;

  item_t    pend_q[$];
  outcome_t tag_results_q[$];
  int       n_offer, n_taken, n_checked, err_cnt, cycles;
  int       gap_left, stall_left;
  bit       quiet, held;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // compute the outcome of one item and update the shadow store
  function automatic outcome_t run_access(item_t it);
    outcome_t r;
    int       ib, ways, set, base, e, found, victim;
    bit       empty, have, better;
    logic [63:0] lo_stamp;
    logic [31:0] lo_cnt;
    r = '{1'b0, 1'b0, 1'b0, 64'd0};
    ib = (c_idx > MaxSetBits) ? MaxSetBits : int'(c_idx);
    ways = 1 << c_way;
    set = int'(it.set) & ((1 << ib) - 1);
    base = set << MaxWayBits;
    found = -1;
    for (int w = 0; w < ways; w++)
      if (found < 0 && sh_valid[base + w] && sh_tag[base + w] == it.tag) found = w;
    if (it.act == ActLookup) begin
      if (!c_dis && found >= 0) begin
        e = base + found;
        r.hit = 1'b1;
        if (c_lfu) begin
          if (sh_cnt[e] != 32'hFFFF_FFFF) sh_cnt[e]++;
          for (int w = 0; w < ways; w++) sh_mru[base + w] = 1'b0;
          sh_mru[e] = 1'b1;
        end else begin
          sh_stamp[e] = sh_clock;
          sh_clock++;
        end
        if (it.wr && c_wb) sh_dirty[e] = 1'b1;
      end
    end else if (it.act == ActInstall || it.act == ActPrefetch) begin
      if (it.act == ActPrefetch && found >= 0) begin
        r.hit = 1'b1;
      end else begin
        // pick an empty way, else the replacement victim
        empty = 0; have = 0; victim = 0; lo_stamp = '0; lo_cnt = '0;
        for (int w = 0; w < ways; w++) begin
          e = base + w;
          better = 0;
          if (!sh_valid[e]) begin
            victim = w;
            empty = 1;
          end else begin
            if (c_lfu) begin
              if (!sh_mru[e]) begin
                if (!have || sh_cnt[e] < lo_cnt) begin
                  have = 1; lo_cnt = sh_cnt[e]; better = 1;
                end else if (sh_cnt[e] == lo_cnt && !empty &&
                             sh_tag[e] < sh_tag[base + victim]) begin
                  better = 1;
                end
              end
            end else if (!have || sh_stamp[e] < lo_stamp) begin
              have = 1; lo_stamp = sh_stamp[e]; better = 1;
            end
            if (!empty && better) victim = w;
          end
        end
        e = base + victim;
        if (sh_valid[e]) begin
          r.evicted = 1'b1;
          if (sh_dirty[e] && c_wb) begin
            r.wb = 1'b1;
            r.addr = ({16'd0, sh_tag[e]} << (ib + c_off)) | (64'(set) << c_off);
          end
        end
        sh_valid[e] = 1'b1;
        sh_tag[e] = it.tag;
        if (it.act == ActInstall) begin
          sh_dirty[e] = it.wr && c_wb;
          if (c_lfu) begin
            sh_cnt[e] = 32'd1;
            for (int w = 0; w < ways; w++) sh_mru[base + w] = 1'b0;
            sh_mru[e] = 1'b1;
          end else begin
            sh_stamp[e] = sh_clock;
            sh_clock++;
          end
        end else begin
          sh_dirty[e] = 1'b0;
          if (c_lfu) begin
            if (c_lip) sh_mru[e] = 1'b0;
            else begin
              for (int w = 0; w < ways; w++) sh_mru[base + w] = 1'b0;
              sh_mru[e] = 1'b1;
            end
            sh_cnt[e] = 32'd0;
          end else begin
            sh_stamp[e] = (c_lip && have) ? lo_stamp - 64'd1 : sh_clock;
            sh_clock++;
          end
        end
      end
    end
    return r;
  endfunction

  // write all seven registers, one per cycle, and mirror them
  task automatic set_config(input logic [3:0] vals[7]);
    for (int i = 0; i < 7; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      case (3'(i))
        RegReplaceLfu: c_lfu = vals[i][0];
        RegWbAlloc:    c_wb  = vals[i][0];
        RegPrefLip:    c_lip = vals[i][0];
        RegDisabled:   c_dis = vals[i][0];
        RegOffset:     c_off = vals[i];
        RegIndex:      c_idx = vals[i];
        RegWay:        c_way = vals[i][1:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every queued item has been taken and answered
  task automatic drain();
    while (pend_q.size() != 0 || n_taken != n_offer || tag_results_q.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [47:0] pick_tag();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return 48'($urandom_range(0, 11));
    if (r < 18) return {16'($urandom), 32'($urandom)};
    if (r == 18) return '1;
    return '0;
  endfunction

  // LFU work stays in the upper half of the sets, LRU work in the lower half,
  // so no line is ever scored on a stamp or count it never got
  function automatic item_t pick_item();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    it.act = (r < 45) ? ActLookup : (r < 80) ? ActInstall : (r < 95) ? ActPrefetch : 2'd3;
    it.wr = 1'($urandom);
    it.tag = pick_tag();
    it.set = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                         : 8'($urandom_range(0, 3));
    if (c_lfu) it.set[7] = 1'b1;
    else if (c_idx >= MaxSetBits) it.set[7] = 1'b0;
    else it.set[7] = 1'($urandom);
    return it;
  endfunction

  // driver: offer items with random gaps
  always @(negedge clk) begin
    if (!rst && (!in_valid || n_taken == n_offer)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_q.size() > 0) begin
        item_t it;
        it = pend_q.pop_front();
        action <= it.act;
        is_write <= it.wr;
        line_tag <= it.tag;
        set_index <= it.set;
        in_valid <= 1'b1;
        n_offer++;
        if (!quiet && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off to back up the pipe
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!held && n_taken >= 60) begin
      held = 1;
      stall_left <= 200;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // check results, then predict newly taken items
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        outcome_t x;
        if (tag_results_q.size() == 0) begin
          $error("result with nothing expected");
          err_cnt++;
        end else begin
          x = tag_results_q.pop_front();
          n_checked++;
          if (hit !== x.hit) begin
            $error("hit: expected %0h, got %0h", x.hit, hit); err_cnt++;
          end
          if (evicted !== x.evicted) begin
            $error("evicted: expected %0h, got %0h", x.evicted, evicted); err_cnt++;
          end
          if (writeback_needed !== x.wb) begin
            $error("writeback_needed: expected %0h, got %0h", x.wb, writeback_needed);
            err_cnt++;
          end
          if (writeback_addr !== x.addr) begin
            $error("writeback_addr: expected %0h, got %0h", x.addr, writeback_addr);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        item_t it;
        it = '{action, is_write, line_tag, set_index};
        tag_results_q.push_back(run_access(it));
        n_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [3:0] phases [NumPhases][7];
    // lfu, wb, lip, disabled, offset, index, way
    phases = '{'{0, 1, 0, 0, 6, 8, 3}, '{1, 1, 0, 0, 12, 8, 3},
               '{0, 0, 1, 0, 0, 3, 2}, '{1, 0, 1, 0, 6, 8, 0},
               '{0, 1, 0, 1, 4, 15, 1}, '{1, 1, 1, 0, 9, 8, 2},
               '{0, 1, 1, 0, 12, 0, 3}, '{1, 1, 0, 1, 3, 8, 3}};
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; action = ActLookup; is_write = 1'b0; line_tag = '0; set_index = '0;
    out_ready = 1'b0;
    n_offer = 0; n_taken = 0; n_checked = 0; err_cnt = 0; cycles = 0;
    gap_left = 0; stall_left = 0; quiet = 0; held = 0;
    for (int i = 0; i < NumLines; i++) begin
      sh_valid[i] = 0; sh_dirty[i] = 0; sh_mru[i] = 0;
      sh_tag[i] = '0; sh_stamp[i] = '0; sh_cnt[i] = '0;
    end
    c_lfu = 0; c_wb = 1; c_lip = 0; c_dis = 0; c_off = 6; c_idx = 8; c_way = 3;
    sh_clock = 64'd4096;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: fill one set, hit it, evict a dirty line, odd action code
    pend_q.push_back('{ActLookup, 1'b0, '1, 8'h05});
    pend_q.push_back('{ActInstall, 1'b1, '1, 8'h05});
    pend_q.push_back('{ActLookup, 1'b1, '1, 8'h05});
    pend_q.push_back('{ActPrefetch, 1'b0, '1, 8'h05});
    for (int t = 1; t <= 8; t++) pend_q.push_back('{ActInstall, 1'b1, 48'(t), 8'h05});
    pend_q.push_back('{ActPrefetch, 1'b1, 48'd20, 8'h05});
    pend_q.push_back('{2'd3, 1'b1, '1, 8'h7F});
    pend_q.push_back('{ActLookup, 1'b0, 48'd0, 8'h00});
    pend_q.push_back('{ActInstall, 1'b0, 48'd0, 8'h7F});
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      set_config(phases[p]);
      if (p == NumPhases - 1) quiet = 1;
      for (int i = 0; i < PhaseItems; i++) pend_q.push_back(pick_item());
      drain();
    end

    repeat (20) @(posedge clk);
    $display("tb: %0d results checked over %0d register settings", n_checked, NumPhases + 1);
    $display("tb: covered LRU/LFU, write-back/through, MIP/LIP, disabled, geometry extremes");
    if (err_cnt == 0 && tag_results_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
